// ===== design/riv_pkg.sv =====
// Shared constants, codes, status types and header tables for the ROM image validator.
package riv_pkg;

    // Width of the saturating byte counter
    localparam int COUNT_BITS = 24;

    // System selector codes
    localparam logic [2:0] KIND_NES      = 3'd0;
    localparam logic [2:0] KIND_HANDHELD = 3'd1;
    localparam logic [2:0] KIND_COLOR    = 3'd2;
    localparam logic [2:0] KIND_TAPE     = 3'd3;
    localparam logic [2:0] KIND_CHIP8    = 3'd4;
    localparam logic [2:0] KIND_NATIVE   = 3'd5;

    // Verdict codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_SIZE = 3'd1,
        ST_BAD_HDR  = 3'd2,
        ST_BAD_SUM  = 3'd3,
        ST_NO_COLOR = 3'd4,
        ST_BAD_TAPE = 3'd5
    } status_t;

    // Image size limits and header offsets
    localparam logic [COUNT_BITS-1:0] MAX_IMAGE    = COUNT_BITS'(8 * 1024 * 1024);
    localparam logic [COUNT_BITS-1:0] CHIP8_MAX    = COUNT_BITS'(65024);
    localparam logic [COUNT_BITS-1:0] HANDHELD_MIN = COUNT_BITS'(16'h0150);
    localparam logic [COUNT_BITS-1:0] NES_MIN      = COUNT_BITS'(16);
    localparam logic [COUNT_BITS-1:0] TAPE_MIN     = COUNT_BITS'(4);
    localparam logic [COUNT_BITS-1:0] LOGO_AT      = COUNT_BITS'(16'h0104);
    localparam logic [COUNT_BITS-1:0] LOGO_END     = COUNT_BITS'(16'h0134);
    localparam logic [COUNT_BITS-1:0] SUM_FIRST    = COUNT_BITS'(16'h0134);
    localparam logic [COUNT_BITS-1:0] SUM_LAST     = COUNT_BITS'(16'h014C);
    localparam logic [COUNT_BITS-1:0] SUM_AT       = COUNT_BITS'(16'h014D);
    localparam logic [COUNT_BITS-1:0] COLOR_AT     = COUNT_BITS'(16'h0143);
    localparam logic [COUNT_BITS-1:0] MAGIC_LEN    = COUNT_BITS'(4);

    localparam logic [7:0] COLOR_DUAL = 8'h80;
    localparam logic [7:0] COLOR_ONLY = 8'hC0;

    // Header flags from the header tracker (values after the current word)
    typedef struct packed {
        logic match;
        logic sum_ok;
        logic color_ok;
    } hdr_flags_t;

    // Block flags from the tape tracker (values after the current word)
    typedef struct packed {
        logic fault;
        logic idle;
        logic block_seen;
    } tape_flags_t;

    // Leading magic of an NES image
    function automatic logic [7:0] nes_magic(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h4E;
            2'd1:    v = 8'h45;
            2'd2:    v = 8'h53;
            default: v = 8'h1A;
        endcase
        return v;
    endfunction

    // 48-byte handheld boot logo
    function automatic logic [7:0] logo_byte(input logic [5:0] idx);
        logic [7:0] v;
        case (idx)
            6'd0:  v = 8'hce; 6'd1:  v = 8'hed; 6'd2:  v = 8'h66; 6'd3:  v = 8'h66;
            6'd4:  v = 8'hcc; 6'd5:  v = 8'h0d; 6'd6:  v = 8'h00; 6'd7:  v = 8'h0b;
            6'd8:  v = 8'h03; 6'd9:  v = 8'h73; 6'd10: v = 8'h00; 6'd11: v = 8'h83;
            6'd12: v = 8'h00; 6'd13: v = 8'h0c; 6'd14: v = 8'h00; 6'd15: v = 8'h0d;
            6'd16: v = 8'h00; 6'd17: v = 8'h08; 6'd18: v = 8'h11; 6'd19: v = 8'h1f;
            6'd20: v = 8'h88; 6'd21: v = 8'h89; 6'd22: v = 8'h00; 6'd23: v = 8'h0e;
            6'd24: v = 8'hdc; 6'd25: v = 8'hcc; 6'd26: v = 8'h6e; 6'd27: v = 8'he6;
            6'd28: v = 8'hdd; 6'd29: v = 8'hdd; 6'd30: v = 8'hd9; 6'd31: v = 8'h99;
            6'd32: v = 8'hbb; 6'd33: v = 8'hbb; 6'd34: v = 8'h67; 6'd35: v = 8'h63;
            6'd36: v = 8'h6e; 6'd37: v = 8'h0e; 6'd38: v = 8'hec; 6'd39: v = 8'hcc;
            6'd40: v = 8'hdd; 6'd41: v = 8'hdc; 6'd42: v = 8'h99; 6'd43: v = 8'h9f;
            6'd44: v = 8'hbb; 6'd45: v = 8'hb9; 6'd46: v = 8'h33; 6'd47: v = 8'h3e;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== design/riv_hdr_track.sv =====
// Header tracker: magic and logo match, header checksum, stored sum and color flag.
module riv_hdr_track
    import riv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic                  clear,
    input  logic [2:0]            kind,
    input  logic [COUNT_BITS-1:0] at,
    input  logic [7:0]            data,
    output hdr_flags_t            flags
);

    logic       match_reg,  match_next;
    logic [7:0] sum_reg,    sum_next;
    logic [7:0] stored_reg, stored_next;
    logic [7:0] color_reg,  color_next;
    logic [COUNT_BITS-1:0] logo_off;

    assign logo_off = at - LOGO_AT;

    // Update header state for the current word
    always_comb begin
        match_next  = match_reg;
        sum_next    = sum_reg;
        stored_next = stored_reg;
        color_next  = color_reg;
        if (kind == KIND_NES) begin
            if (at < MAGIC_LEN && data != nes_magic(at[1:0])) begin
                match_next = 1'b0;
            end
        end else if (kind == KIND_HANDHELD || kind == KIND_COLOR) begin
            if (at >= LOGO_AT && at < LOGO_END && data != logo_byte(logo_off[5:0])) begin
                match_next = 1'b0;
            end
            if (at >= SUM_FIRST && at <= SUM_LAST) begin
                sum_next = sum_reg - data - 8'd1;
            end
            if (at == COLOR_AT) begin
                color_next = data;
            end
            if (at == SUM_AT) begin
                stored_next = data;
            end
        end
    end

    assign flags.match    = match_next;
    assign flags.sum_ok   = (sum_next == stored_next);
    assign flags.color_ok = (color_next == COLOR_DUAL) || (color_next == COLOR_ONLY);

    // Hold state; return to reset after the last word of an image
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && clear)) begin
            match_reg  <= 1'b1;
            sum_reg    <= 8'h00;
            stored_reg <= 8'h00;
            color_reg  <= 8'h00;
        end else if (step) begin
            match_reg  <= match_next;
            sum_reg    <= sum_next;
            stored_reg <= stored_next;
            color_reg  <= color_next;
        end
    end

endmodule

// ===== design/riv_tape_track.sv =====
// Tape tracker: length-prefixed block parser with running XOR check.
module riv_tape_track
    import riv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        clear,
    input  logic [7:0]  data,
    output tape_flags_t flags
);

    typedef enum logic [1:0] {
        PH_LEN_LO = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] remain_reg, remain_next;
    logic [7:0]  parity_reg, parity_next;
    logic        seen_reg, seen_next;
    logic        fault_reg, fault_next;

    // Advance the block parser by one word
    always_comb begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        parity_next = parity_reg;
        seen_next   = seen_reg;
        fault_next  = fault_reg;
        case (phase_reg)
            PH_LEN_LO: begin
                remain_next = {8'h00, data};
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                remain_next = {data, remain_reg[7:0]};
                parity_next = 8'h00;
                if (remain_next < 16'd2) begin
                    fault_next = 1'b1;
                    phase_next = PH_LEN_LO;
                end else begin
                    phase_next = PH_BODY;
                end
            end
            default: begin
                parity_next = parity_reg ^ data;
                remain_next = remain_reg - 16'd1;
                if (remain_next == 16'd0) begin
                    if (parity_next != 8'h00) begin
                        fault_next = 1'b1;
                    end else begin
                        seen_next = 1'b1;
                    end
                    phase_next = PH_LEN_LO;
                end
            end
        endcase
    end

    assign flags.fault      = fault_next;
    assign flags.idle       = (phase_next == PH_LEN_LO);
    assign flags.block_seen = seen_next;

    // Hold parser state; return to reset after the last word of an image
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && clear)) begin
            phase_reg  <= PH_LEN_LO;
            remain_reg <= 16'h0000;
            parity_reg <= 8'h00;
            seen_reg   <= 1'b0;
            fault_reg  <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            parity_reg <= parity_next;
            seen_reg   <= seen_next;
            fault_reg  <= fault_next;
        end
    end

endmodule

// ===== design/rom_image_validator.sv =====
// Top level of the ROM image validator: word register, trackers, verdict and result register.
//
// Usage:
//   The image enters on the s_ channel one byte per word, in file order, with
//   s_tlast on its final byte. The system to check against is set through
//   cfg_wr_en/cfg_wr_data while no image is in flight (0 nes, 1 handheld,
//   2 color handheld, 3 tape, 4 chip8, 5 launcher native).
//   Only the final byte of an image produces a result word on the m_ channel:
//   a status code and an ok flag. Other bytes produce nothing.
// Flow:
//   One byte per cycle unless a final byte waits on a full result register.
//   A byte is held in the input register while the trackers and verdict
//   logic evaluate it; when it is processed the trackers update and, on a
//   final byte, the verdict loads into the result register, which drives m_tvalid. The byte
//   counter, header tracker and tape parser each take one update a cycle, on each processed byte.
// Reset and stall:
//   Reset selects nes and clears all stream state; the stream state also
//   returns to reset after every verdict. While a verdict waits on m_tready,
//   bytes of the next image keep flowing; only a second final byte waits in
//   the input register until the result register frees.
module rom_image_validator
    import riv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_wr_data,    // system_kind
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,        // [7:0] data_byte
    input  logic       s_tlast,        // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata         // [2:0] status_code, [3] image_ok, [7:4] zero
);

    logic                  in_valid_reg;
    logic [7:0]            in_data_reg;
    logic                  in_last_reg;
    logic [2:0]            kind_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic                  out_ok_reg;
    logic                  proc;
    logic                  done;
    hdr_flags_t            hdr_flags;
    tape_flags_t           tape_flags;
    status_t               verdict;

    // Process the held word unless it is a final word facing a full result register that is not taken
    assign proc     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign done     = proc && in_last_reg;
    assign s_tready = !in_valid_reg || proc;

    // Hold the system selector
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_NES;
        end else if (cfg_wr_en) begin
            kind_reg <= cfg_wr_data;
        end
    end

    // Capture incoming words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Saturating byte counter
    assign count_next = (count_reg != {COUNT_BITS{1'b1}}) ? count_reg + 1'b1 : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || done) begin
            count_reg <= '0;
        end else if (proc) begin
            count_reg <= count_next;
        end
    end

    riv_hdr_track u_hdr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (proc),
        .clear   (in_last_reg),
        .kind    (kind_reg),
        .at      (count_reg),
        .data    (in_data_reg),
        .flags   (hdr_flags)
    );

    riv_tape_track u_tape (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (proc),
        .clear   (in_last_reg),
        .data    (in_data_reg),
        .flags   (tape_flags)
    );

    // Pick the verdict for the selected system
    always_comb begin
        case (kind_reg)
            KIND_NES: begin
                if (count_next < NES_MIN || !hdr_flags.match) begin
                    verdict = ST_BAD_HDR;
                end else begin
                    verdict = ST_OK;
                end
            end
            KIND_HANDHELD, KIND_COLOR: begin
                if (count_next < HANDHELD_MIN || count_next > MAX_IMAGE) begin
                    verdict = ST_BAD_SIZE;
                end else if (!hdr_flags.match) begin
                    verdict = ST_BAD_HDR;
                end else if (!hdr_flags.sum_ok) begin
                    verdict = ST_BAD_SUM;
                end else if (kind_reg == KIND_COLOR && !hdr_flags.color_ok) begin
                    verdict = ST_NO_COLOR;
                end else begin
                    verdict = ST_OK;
                end
            end
            KIND_TAPE: begin
                if (count_next < TAPE_MIN || count_next > MAX_IMAGE) begin
                    verdict = ST_BAD_SIZE;
                end else if (tape_flags.fault || !tape_flags.idle
                             || !tape_flags.block_seen) begin
                    verdict = ST_BAD_TAPE;
                end else begin
                    verdict = ST_OK;
                end
            end
            KIND_CHIP8: begin
                if (count_next > CHIP8_MAX) begin
                    verdict = ST_BAD_SIZE;
                end else begin
                    verdict = ST_OK;
                end
            end
            KIND_NATIVE: verdict = ST_OK;
            default:     verdict = ST_BAD_HDR;
        endcase
    end

    // Result register: load on a final word, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            out_status_reg <= verdict;
            out_ok_reg     <= (verdict == ST_OK);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_ok_reg, out_status_reg};

    // A result word appears only after a final word was processed
    a_out_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(done))
        else $error("result word without a final input word");

    // The byte counter restarts after every verdict
    a_count_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> (count_reg == '0))
        else $error("byte counter not cleared after verdict");

    // The ok flag agrees with the status code
    a_ok_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_ok_reg == (out_status_reg == ST_OK)))
        else $error("image_ok disagrees with status_code");

    // Input backpressure only while a final word waits on a full result register
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && in_last_reg && m_tvalid && !m_tready))
        else $error("input stalled without a pending result");

endmodule

// ===== tb/tb_rom_image_validator.sv =====
// Self-checking testbench for rom_image_validator: directed and random images with a verdict predictor.
module tb_rom_image_validator;
    timeunit 1ns;
    timeprecision 1ps;

    import riv_pkg::*;

    // Unassigned system codes, answered with a bad header verdict
    localparam logic [2:0] KIND_RSVD_A = 3'd6;
    localparam logic [2:0] KIND_RSVD_B = 3'd7;

    // Image layout and size limits
    localparam int NES_MIN_LEN   = 16;
    localparam int HH_MIN_LEN    = 'h150;
    localparam int TAPE_MIN_LEN  = 4;
    localparam int IMG_MAX_LEN   = 8 * 1024 * 1024;
    localparam int CHIP8_MAX_LEN = 65024;
    localparam int LOGO_OFS      = 'h104;
    localparam int LOGO_LEN      = 48;
    localparam int CSUM_FIRST    = 'h134;
    localparam int CSUM_LAST     = 'h14C;
    localparam int CSUM_OFS      = 'h14D;
    localparam int CFLAG_OFS     = 'h143;
    localparam logic [7:0] CFLAG_DUAL = 8'h80;
    localparam logic [7:0] CFLAG_ONLY = 8'hC0;

    localparam logic [7:0] NES_SIG [4] = '{8'h4E, 8'h45, 8'h53, 8'h1A};
    localparam logic [7:0] BOOT_LOGO [48] = '{
        8'hce, 8'hed, 8'h66, 8'h66, 8'hcc, 8'h0d, 8'h00, 8'h0b, 8'h03, 8'h73, 8'h00, 8'h83,
        8'h00, 8'h0c, 8'h00, 8'h0d, 8'h00, 8'h08, 8'h11, 8'h1f, 8'h88, 8'h89, 8'h00, 8'h0e,
        8'hdc, 8'hcc, 8'h6e, 8'he6, 8'hdd, 8'hdd, 8'hd9, 8'h99, 8'hbb, 8'hbb, 8'h67, 8'h63,
        8'h6e, 8'h0e, 8'hec, 8'hcc, 8'hdd, 8'hdc, 8'h99, 8'h9f, 8'hbb, 8'hb9, 8'h33, 8'h3e};

    // Run control
    localparam int LIMIT_CYCLES  = 1500000;
    localparam int DRAIN_GUARD   = 10000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BYTES   = 290;
    localparam int PHASE_IMAGES  = 10;

    typedef enum logic [1:0] {TP_LEN_LO, TP_LEN_HI, TP_BODY} tape_step_t;
    typedef enum int {HH_CLEAN, HH_BAD_LOGO, HH_BAD_SUM} hh_fault_t;
    typedef enum int {
        TF_CLEAN, TF_BAD_XOR, TF_SHORT_LEN, TF_CUT, TF_DANGLING, TF_NO_BLOCK
    } tape_fault_t;
    typedef struct packed {
        status_t status;
        logic    ok;
    } verdict_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [2:0] cfg_wr_data = 3'd0;   // system_kind
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = 8'd0;   // [7:0] data_byte
    logic       s_tlast     = 1'b0;   // last_byte
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;              // [2:0] status_code, [3] image_ok, [7:4] zero

    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned err_count     = 0;
    int unsigned cycle_count   = 0;

    // Predictor state, mirrors the block's stream state
    logic [2:0]            sel_kind   = KIND_NES;
    logic [COUNT_BITS-1:0] img_count  = '0;
    logic                  hdr_ok     = 1'b1;
    logic [7:0]            hdr_sum    = 8'd0;
    logic [7:0]            hdr_stored = 8'd0;
    logic [7:0]            hdr_color  = 8'd0;
    tape_step_t            tp_step    = TP_LEN_LO;
    logic [15:0]           tp_left    = 16'd0;
    logic [7:0]            tp_xor     = 8'd0;
    logic                  tp_seen    = 1'b0;
    logic                  tp_bad     = 1'b0;

    verdict_t   pending_verdicts[$];
    logic [7:0] img_bytes[$];

    rom_image_validator u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Count cycles for the watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("TB_ERROR");
        $finish;
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // Append one byte to the image under construction
    function automatic void append_byte(input logic [7:0] b);
        img_bytes.insert(img_bytes.size(), b);
    endfunction

    // Queue one expected verdict behind the older ones
    function automatic void expect_verdict(input verdict_t v);
        pending_verdicts.insert(pending_verdicts.size(), v);
    endfunction

    // Judge the finished image against the selected system
    function automatic status_t judge_image();
        status_t st;
        case (sel_kind)
            KIND_NES: begin
                st = (img_count < NES_MIN_LEN || !hdr_ok) ? ST_BAD_HDR : ST_OK;
            end
            KIND_HANDHELD, KIND_COLOR: begin
                if (img_count < HH_MIN_LEN || img_count > IMG_MAX_LEN)
                    st = ST_BAD_SIZE;
                else if (!hdr_ok)
                    st = ST_BAD_HDR;
                else if (hdr_sum != hdr_stored)
                    st = ST_BAD_SUM;
                else if (sel_kind == KIND_COLOR && hdr_color != CFLAG_DUAL
                         && hdr_color != CFLAG_ONLY)
                    st = ST_NO_COLOR;
                else
                    st = ST_OK;
            end
            KIND_TAPE: begin
                if (img_count < TAPE_MIN_LEN || img_count > IMG_MAX_LEN)
                    st = ST_BAD_SIZE;
                else if (tp_bad || tp_step != TP_LEN_LO || !tp_seen)
                    st = ST_BAD_TAPE;
                else
                    st = ST_OK;
            end
            KIND_CHIP8: begin
                st = (img_count < 1 || img_count > CHIP8_MAX_LEN) ? ST_BAD_SIZE : ST_OK;
            end
            KIND_NATIVE: st = ST_OK;
            default:     st = ST_BAD_HDR;
        endcase
        return st;
    endfunction

    // Advance the predictor by one accepted word
    function automatic void track_byte(input logic [7:0] b, input logic lst);
        int       at;
        verdict_t v;
        at = int'(img_count);
        // header tracking for the selected system
        if (sel_kind == KIND_NES) begin
            if (at < 4 && b != NES_SIG[at])
                hdr_ok = 1'b0;
        end else if (sel_kind == KIND_HANDHELD || sel_kind == KIND_COLOR) begin
            if (at >= LOGO_OFS && at < LOGO_OFS + LOGO_LEN && b != BOOT_LOGO[at - LOGO_OFS])
                hdr_ok = 1'b0;
            if (at >= CSUM_FIRST && at <= CSUM_LAST)
                hdr_sum = hdr_sum - b - 8'd1;
            if (at == CFLAG_OFS)
                hdr_color = b;
            if (at == CSUM_OFS)
                hdr_stored = b;
        end
        // tape block parsing runs for every system
        case (tp_step)
            TP_LEN_LO: begin
                tp_left = {8'h00, b};
                tp_step = TP_LEN_HI;
            end
            TP_LEN_HI: begin
                tp_left = {b, tp_left[7:0]};
                tp_xor  = 8'd0;
                if (tp_left < 16'd2) begin
                    tp_bad  = 1'b1;
                    tp_step = TP_LEN_LO;
                end else begin
                    tp_step = TP_BODY;
                end
            end
            default: begin
                tp_xor  = tp_xor ^ b;
                tp_left = tp_left - 16'd1;
                if (tp_left == 16'd0) begin
                    if (tp_xor != 8'd0)
                        tp_bad = 1'b1;
                    else
                        tp_seen = 1'b1;
                    tp_step = TP_LEN_LO;
                end
            end
        endcase
        // saturate the byte counter
        if (img_count != '1)
            img_count = img_count + 1'b1;
        if (lst) begin
            v.status = judge_image();
            v.ok     = (v.status == ST_OK);
            expect_verdict(v);
            img_count  = '0;
            hdr_ok     = 1'b1;
            hdr_sum    = 8'd0;
            hdr_stored = 8'd0;
            hdr_color  = 8'd0;
            tp_step    = TP_LEN_LO;
            tp_left    = 16'd0;
            tp_xor     = 8'd0;
            tp_seen    = 1'b0;
            tp_bad     = 1'b0;
        end
    endfunction

    // Compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin : check_results
        verdict_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected result word 0x%02h", m_tdata));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report_mismatch($sformatf("status_code got %0d expected %0d",
                                              m_tdata[2:0], want.status));
                if (m_tdata[3] !== want.ok)
                    report_mismatch($sformatf("image_ok got %b expected %b",
                                              m_tdata[3], want.ok));
                if (m_tdata[7:4] !== 4'd0)
                    report_mismatch($sformatf("padding got 0x%h expected 0", m_tdata[7:4]));
            end
        end
    end

    // Send one word, with random idle cycles ahead of it
    task automatic send_word(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        track_byte(b, lst);
    endtask

    task automatic send_image();
        for (int i = 0; i < img_bytes.size(); i++)
            send_word(img_bytes[i], i == img_bytes.size() - 1);
    endtask

    // Hold the sender until every expected verdict has come back
    task automatic wait_drained();
        int unsigned guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (pending_verdicts.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        if (pending_verdicts.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
            pending_verdicts.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Select the system while the block is idle
    task automatic set_kind(input logic [2:0] k);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sel_kind = k;
    endtask

    function automatic void push_random(input int n);
        for (int i = 0; i < n; i++)
            append_byte(8'($urandom));
    endfunction

    // NES image with the magic in place; bad_at >= 0 corrupts that byte
    function automatic void build_nes(input int n, input int bad_at);
        img_bytes.delete();
        push_random(n);
        for (int k = 0; k < 4 && k < n; k++)
            img_bytes[k] = NES_SIG[k];
        if (bad_at >= 0 && bad_at < n)
            img_bytes[bad_at] = img_bytes[bad_at] ^ 8'($urandom_range(1, 255));
    endfunction

    // Handheld image with logo, color flag and a matching header checksum, then the chosen fault
    function automatic void build_handheld(input int n, input hh_fault_t fault,
                                           input logic [7:0] cflag);
        logic [7:0] sum;
        int         k;
        img_bytes.delete();
        push_random(n);
        for (k = 0; k < LOGO_LEN; k++)
            if (LOGO_OFS + k < n)
                img_bytes[LOGO_OFS + k] = BOOT_LOGO[k];
        if (CFLAG_OFS < n)
            img_bytes[CFLAG_OFS] = cflag;
        sum = 8'd0;
        for (k = CSUM_FIRST; k <= CSUM_LAST && k < n; k++)
            sum = sum - img_bytes[k] - 8'd1;
        if (CSUM_OFS < n)
            img_bytes[CSUM_OFS] = sum;
        case (fault)
            HH_BAD_LOGO: begin
                k = LOGO_OFS + $urandom_range(0, LOGO_LEN - 1);
                if (k < n)
                    img_bytes[k] = img_bytes[k] ^ 8'($urandom_range(1, 255));
            end
            HH_BAD_SUM: begin
                if (CSUM_OFS < n)
                    img_bytes[CSUM_OFS] = img_bytes[CSUM_OFS] ^ 8'($urandom_range(1, 255));
            end
            default: ;
        endcase
    endfunction

    // Tape image of length-prefixed blocks whose bytes XOR to zero, then the chosen fault
    function automatic void build_tape(input int blocks, input tape_fault_t fault);
        int         len;
        int         k;
        logic [7:0] acc;
        logic [7:0] b;
        img_bytes.delete();
        if (fault == TF_NO_BLOCK) begin
            push_random($urandom_range(1, 3));
            return;
        end
        for (int blk = 0; blk < blocks; blk++) begin
            len = ($urandom_range(15) == 0) ? $urandom_range(256, 300) : $urandom_range(2, 10);
            append_byte(len[7:0]);
            append_byte(len[15:8]);
            acc = 8'd0;
            for (k = 0; k < len - 1; k++) begin
                b   = 8'($urandom);
                acc = acc ^ b;
                append_byte(b);
            end
            append_byte(acc);
        end
        case (fault)
            TF_BAD_XOR: begin
                img_bytes[img_bytes.size() - 1] =
                    img_bytes[img_bytes.size() - 1] ^ 8'($urandom_range(1, 255));
            end
            TF_SHORT_LEN: begin
                img_bytes.push_front(8'h00);
                img_bytes.push_front(8'($urandom_range(0, 1)));
            end
            TF_CUT: begin
                repeat ($urandom_range(1, 3)) void'(img_bytes.pop_back());
            end
            TF_DANGLING: append_byte(8'($urandom));
            default: ;
        endcase
    endfunction

    // Build and send one random image, mostly well formed for the given system
    task automatic send_random_image(input logic [2:0] k);
        int          n;
        int unsigned r;
        hh_fault_t   hf;
        logic [7:0]  cflag;
        if ($urandom_range(9) == 0) begin
            // noise
            img_bytes.delete();
            push_random($urandom_range(1, 24));
        end else begin
            case (k)
                KIND_NES: begin
                    build_nes($urandom_range(1, 40),
                              ($urandom_range(3) == 0) ? int'($urandom_range(0, 5)) : -1);
                end
                KIND_HANDHELD, KIND_COLOR: begin
                    n  = ($urandom_range(7) == 0) ? $urandom_range(1, HH_MIN_LEN - 1)
                                                  : HH_MIN_LEN + $urandom_range(0, 24);
                    r  = $urandom_range(9);
                    hf = (r == 0) ? HH_BAD_LOGO : (r == 1) ? HH_BAD_SUM : HH_CLEAN;
                    r  = $urandom_range(5);
                    cflag = (r < 2) ? CFLAG_DUAL : (r < 4) ? CFLAG_ONLY : 8'($urandom);
                    build_handheld(n, hf, cflag);
                end
                KIND_TAPE: begin
                    r = $urandom_range(9);
                    build_tape($urandom_range(1, 4),
                               (r < 5) ? TF_CLEAN : tape_fault_t'(r - 4));
                end
                KIND_CHIP8: begin
                    img_bytes.delete();
                    push_random($urandom_range(1, 64));
                end
                default: begin
                    img_bytes.delete();
                    push_random($urandom_range(1, 24));
                end
            endcase
        end
        send_image();
    endtask

    task automatic test_nes();
        set_kind(KIND_NES);
        build_nes(NES_MIN_LEN, -1);     send_image();
        build_nes(NES_MIN_LEN - 1, -1); send_image();
        build_nes(20, 3);               send_image();
        build_nes(20, 0);               send_image();
        build_nes(1, -1);               send_image();
    endtask

    task automatic test_handheld();
        set_kind(KIND_HANDHELD);
        build_handheld(HH_MIN_LEN, HH_CLEAN, 8'h00);        send_image();
        build_handheld(HH_MIN_LEN - 1, HH_CLEAN, 8'h00);    send_image();
        build_handheld(HH_MIN_LEN, HH_BAD_LOGO, 8'h00);     send_image();
        build_handheld(HH_MIN_LEN + 8, HH_BAD_SUM, 8'h00);  send_image();
    endtask

    task automatic test_color_handheld();
        set_kind(KIND_COLOR);
        build_handheld(HH_MIN_LEN, HH_CLEAN, CFLAG_DUAL);   send_image();
        build_handheld(HH_MIN_LEN, HH_CLEAN, CFLAG_ONLY);   send_image();
        build_handheld(HH_MIN_LEN, HH_CLEAN, 8'h00);        send_image();
    endtask

    task automatic test_tape();
        set_kind(KIND_TAPE);
        img_bytes = '{8'h02, 8'h00, 8'h5A, 8'h5A};          send_image();
        img_bytes = '{8'h02, 8'h00, 8'h00};                 send_image();
        build_tape(3, TF_CLEAN);                            send_image();
        build_tape(1, TF_BAD_XOR);                          send_image();
        build_tape(2, TF_SHORT_LEN);                        send_image();
        build_tape(1, TF_CUT);                              send_image();
        build_tape(1, TF_DANGLING);                         send_image();
        img_bytes = '{8'h00, 8'h00, 8'h01, 8'h00};          send_image();
        img_bytes = '{8'hFF, 8'hFF, 8'h00, 8'hFF};          send_image();
    endtask

    task automatic test_chip8();
        set_kind(KIND_CHIP8);
        img_bytes.delete(); push_random(1);                 send_image();
        img_bytes.delete(); push_random(2);                 send_image();
        img_bytes.delete(); push_random(64);                send_image();
    endtask

    task automatic test_native();
        set_kind(KIND_NATIVE);
        img_bytes = '{8'h00, 8'hFF};                        send_image();
        img_bytes = '{8'hFF};                               send_image();
    endtask

    task automatic test_reserved_kinds();
        set_kind(KIND_RSVD_A);
        build_nes(NES_MIN_LEN, -1);                         send_image();
        set_kind(KIND_RSVD_B);
        img_bytes.delete(); push_random(5);                 send_image();
    endtask

    // Random images over random systems under one idle setting
    task automatic test_random_mix(input int unsigned src_pct, input int unsigned snk_pct);
        int unsigned phase_bytes;
        int unsigned phase_images;
        int unsigned r;
        logic [2:0]  kind;
        wait_drained();
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        phase_bytes   = 0;
        phase_images  = 0;
        while (phase_bytes < PHASE_BYTES || phase_images < PHASE_IMAGES) begin
            r = $urandom_range(15);
            if (r < 3)
                kind = KIND_NES;
            else if (r == 3)
                kind = $urandom_range(1) ? KIND_HANDHELD : KIND_COLOR;
            else if (r < 8)
                kind = KIND_TAPE;
            else if (r < 11)
                kind = KIND_CHIP8;
            else if (r < 14)
                kind = KIND_NATIVE;
            else
                kind = (r == 14) ? KIND_RSVD_A : KIND_RSVD_B;
            set_kind(kind);
            repeat ($urandom_range(1, 4)) begin
                send_random_image(kind);
                phase_images++;
                phase_bytes += img_bytes.size();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_nes();
        test_handheld();
        test_color_handheld();
        test_tape();
        test_chip8();
        test_native();
        test_reserved_kinds();
        test_random_mix(0, 0);
        test_random_mix(71, 0);
        test_random_mix(0, 71);
        test_random_mix(17, 17);
        wait_drained();
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
